// ===== rtl/memory_request_classifier_unit_defines.svh =====
// Assertion macros shared by the memory request classifier.
`ifndef MEMORY_REQUEST_CLASSIFIER_UNIT_DEFINES_SVH
`define MEMORY_REQUEST_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MRC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mrc_pkg.sv =====
// Types, codes and constants of the memory request classifier.
package mrc_pkg;

    localparam logic [3:0] OP_H2D       = 4'd0;
    localparam logic [3:0] OP_D2H       = 4'd1;
    localparam logic [3:0] OP_LOAD      = 4'd2;
    localparam logic [3:0] OP_STORE     = 4'd3;
    localparam logic [3:0] OP_ADD       = 4'd4;
    localparam logic [3:0] OP_BARRIER   = 4'd9;
    localparam logic [3:0] OP_NTT       = 4'd10;
    localparam logic [3:0] OP_INTT      = 4'd11;

    localparam logic MODE_FABRIC  = 1'b0;
    localparam logic MODE_COMPUTE = 1'b1;

    localparam logic [1:0] ACT_COMPLETE = 2'd0;
    localparam logic [1:0] ACT_COMPUTE  = 2'd1;
    localparam logic [1:0] ACT_MEMORY   = 2'd2;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    localparam logic [2:0] REG_CAPACITY   = 3'd0;
    localparam logic [2:0] REG_BURST      = 3'd1;
    localparam logic [2:0] REG_BASE       = 3'd2;
    localparam logic [2:0] REG_CPB        = 3'd3;
    localparam logic [2:0] REG_CMP_DELAY  = 3'd4;
    localparam logic [2:0] REG_RET_DELAY  = 3'd5;
    localparam logic [2:0] REG_TWIDDLE_EN = 3'd6;
    localparam logic [2:0] REG_CHANNELS   = 3'd7;

    localparam logic [24:0] DEFAULT_POLY_DEGREE = 25'd8192;
    localparam logic [32:0] TW_ELEM_BYTES       = 33'd4;

    localparam int DIV_BITS   = 48;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;

    localparam logic [42:0] CYCLES_MAX = 43'h00FF_FFFF_FFFF;

    typedef struct packed {
        logic        mode;
        logic [3:0]  opcode;
        logic [47:0] mem_address;
        logic [31:0] byte_count;
        logic [24:0] elem_count;
        logic [24:0] poly_deg;
        logic [47:0] twiddle_addr;
    } req_t;

    typedef struct packed {
        logic [1:0]  action;
        logic        status;
        logic [7:0]  channel;
        logic [39:0] cycles;
        logic [47:0] access_address;
        logic [31:0] access_bytes;
        logic        needs_ready;
        logic        marks_valid;
        logic        then_compute;
        logic        then_fabric;
    } rsp_t;

    typedef struct packed {
        logic [47:0] capacity;
        logic [15:0] burst;
        logic [15:0] base;
        logic [7:0]  cpb;
        logic [15:0] cmp_delay;
        logic [15:0] ret_delay;
        logic        twiddle_en;
        logic [8:0]  chans;
    } cfg_t;

    typedef struct packed {
        logic        is_mem;
        logic [1:0]  action;
        logic        status;
        logic [15:0] delay;
        logic [47:0] addr;
        logic [32:0] bytes;
        logic [3:0]  flags;
        logic [47:0] da;
        logic [47:0] db;
        logic [15:0] ra;
        logic [15:0] rb;
        logic [8:0]  rc;
        logic [33:0] qb;
    } item_t;

    function automatic logic fits(input logic [47:0] addr, input logic [32:0] bytes,
                                  input logic [47:0] cap);
        logic [47:0] room;
        room = cap - addr;
        return (addr <= cap) && ({15'd0, bytes} <= room);
    endfunction

endpackage

// ===== rtl/mrc_cfg.sv =====
// Register file of the classifier behind its APB-style port.
module mrc_cfg import mrc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [47:0] capacity_reg;
    logic [15:0] burst_reg;
    logic [15:0] base_reg;
    logic [7:0]  cpb_reg;
    logic [15:0] cmp_delay_reg;
    logic [15:0] ret_delay_reg;
    logic        twiddle_en_reg;
    logic [8:0]  chans_reg;
    logic        wr;
    logic [2:0]  idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= 48'd17179869184;
            burst_reg      <= 16'd64;
            base_reg       <= 16'd24;
            cpb_reg        <= 8'd2;
            cmp_delay_reg  <= 16'd2;
            ret_delay_reg  <= 16'd4;
            twiddle_en_reg <= 1'b0;
            chans_reg      <= 9'd16;
        end
        else if (wr)
        begin
            case (idx)
                REG_CAPACITY:   capacity_reg   <= pwdata[47:0];
                REG_BURST:      burst_reg      <= pwdata[15:0];
                REG_BASE:       base_reg       <= pwdata[15:0];
                REG_CPB:        cpb_reg        <= pwdata[7:0];
                REG_CMP_DELAY:  cmp_delay_reg  <= pwdata[15:0];
                REG_RET_DELAY:  ret_delay_reg  <= pwdata[15:0];
                REG_TWIDDLE_EN: twiddle_en_reg <= pwdata[0];
                REG_CHANNELS:   chans_reg      <= pwdata[8:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_CAPACITY:   prdata = {16'd0, capacity_reg};
            REG_BURST:      prdata = {48'd0, burst_reg};
            REG_BASE:       prdata = {48'd0, base_reg};
            REG_CPB:        prdata = {56'd0, cpb_reg};
            REG_CMP_DELAY:  prdata = {48'd0, cmp_delay_reg};
            REG_RET_DELAY:  prdata = {48'd0, ret_delay_reg};
            REG_TWIDDLE_EN: prdata = {63'd0, twiddle_en_reg};
            REG_CHANNELS:   prdata = {55'd0, chans_reg};
            default:        prdata = 64'd0;
        endcase
    end

    always_comb
    begin
        cfg.capacity   = capacity_reg;
        cfg.burst      = (burst_reg == 16'd0) ? 16'd1 : burst_reg;
        cfg.base       = (base_reg == 16'd0) ? 16'd1 : base_reg;
        cfg.cpb        = (cpb_reg == 8'd0) ? 8'd1 : cpb_reg;
        cfg.cmp_delay  = (cmp_delay_reg == 16'd0) ? 16'd1 : cmp_delay_reg;
        cfg.ret_delay  = (ret_delay_reg == 16'd0) ? 16'd1 : ret_delay_reg;
        cfg.twiddle_en = twiddle_en_reg;
        if (chans_reg == 9'd0)
        begin
            cfg.chans = 9'd1;
        end
        else if (chans_reg > 9'd256)
        begin
            cfg.chans = 9'd256;
        end
        else
        begin
            cfg.chans = chans_reg;
        end
    end

endmodule

// ===== rtl/mrc_div_stage.sv =====
// One registered stage of the shared channel and burst-count divider chain.
module mrc_div_stage import mrc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  item_t       in_item,
    input  logic [15:0] burst,
    input  logic [8:0]  chans,
    output logic        out_valid,
    output item_t       out_item
);

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    always_comb
    begin
        logic [16:0] ta;
        logic [16:0] tb;
        logic [9:0]  tc;
        logic        qa;
        logic        qbit;
        item_next = in_item;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            ta = {item_next.ra, item_next.da[47]};
            qa = (ta >= {1'b0, burst});
            ta = qa ? (ta - {1'b0, burst}) : ta;
            item_next.ra = ta[15:0];
            item_next.da = {item_next.da[46:0], 1'b0};

            tc = {item_next.rc, qa};
            tc = (tc >= {1'b0, chans}) ? (tc - {1'b0, chans}) : tc;
            item_next.rc = tc[8:0];

            tb = {item_next.rb, item_next.db[47]};
            qbit = (tb >= {1'b0, burst});
            tb = qbit ? (tb - {1'b0, burst}) : tb;
            item_next.rb = tb[15:0];
            item_next.db = {item_next.db[46:0], 1'b0};
            item_next.qb = {item_next.qb[32:0], qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== rtl/mrc_front.sv =====
// Front pipeline: classifies each request and works out channel and service cycles.
module mrc_front import mrc_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  req_t  req,
    input  cfg_t  cfg,
    output logic  keep,
    output logic  res_valid,
    output rsp_t  res
);

    item_t       cls;
    logic        cls_keep;
    logic [32:0] bytes_c;
    logic [32:0] tw_bytes;
    logic [24:0] deg;
    logic [24:0] ec_nz;
    logic [33:0] ceil_sum;

    logic        s0_valid_reg;
    item_t       s0_item_reg;
    logic        chain_valid [DIV_STAGES+1];
    item_t       chain_item  [DIV_STAGES+1];
    logic        mul_valid_reg;
    item_t       mul_item_reg;
    logic [41:0] prod_reg;
    logic        fin_valid_reg;
    rsp_t        fin_reg;
    rsp_t        fin_next;
    logic [33:0] bursts;
    logic [42:0] cyc;

    always_comb
    begin
        ec_nz   = (req.elem_count == 25'd0) ? 25'd1 : req.elem_count;
        bytes_c = (req.byte_count != 32'd0) ? {1'b0, req.byte_count} : {6'd0, ec_nz, 2'b00};
        if (req.poly_deg != 25'd0)
        begin
            deg = req.poly_deg;
        end
        else if (req.elem_count != 25'd0)
        begin
            deg = req.elem_count;
        end
        else
        begin
            deg = DEFAULT_POLY_DEGREE;
        end
        if (deg < 25'd2)
        begin
            deg = 25'd2;
        end
        tw_bytes = {9'd0, deg[24:1]} * TW_ELEM_BYTES;

        cls        = '0;
        cls_keep   = 1'b1;
        cls.addr   = req.mem_address;
        cls.bytes  = bytes_c;
        cls.action = ACT_COMPLETE;
        cls.status = STATUS_OK;
        cls.delay  = cfg.ret_delay;

        if (req.mode == MODE_COMPUTE)
        begin
            if (req.opcode == OP_STORE)
            begin
                if (fits(req.mem_address, bytes_c, cfg.capacity))
                begin
                    cls.is_mem = 1'b1;
                    cls.flags  = 4'b0101;
                end
                else
                begin
                    cls.status = STATUS_INVALID;
                end
            end
        end
        else
        begin
            case (req.opcode) inside
                OP_H2D, OP_D2H, OP_LOAD:
                begin
                    if (!fits(req.mem_address, bytes_c, cfg.capacity))
                    begin
                        cls.status = STATUS_INVALID;
                    end
                    else
                    begin
                        cls.is_mem = 1'b1;
                        case (req.opcode)
                            OP_H2D:  cls.flags = 4'b0101;
                            OP_D2H:  cls.flags = 4'b1001;
                            default: cls.flags = 4'b1010;
                        endcase
                    end
                end
                [OP_STORE:OP_BARRIER]:
                begin
                    cls.action = ACT_COMPUTE;
                    cls.delay  = cfg.cmp_delay;
                end
                OP_NTT, OP_INTT:
                begin
                    if (cfg.twiddle_en)
                    begin
                        cls.addr  = req.twiddle_addr;
                        cls.bytes = tw_bytes;
                        if (fits(req.twiddle_addr, tw_bytes, cfg.capacity))
                        begin
                            cls.is_mem = 1'b1;
                            cls.flags  = 4'b1010;
                        end
                        else
                        begin
                            cls.status = STATUS_INVALID;
                        end
                    end
                    else
                    begin
                        cls.action = ACT_COMPUTE;
                        cls.delay  = cfg.cmp_delay;
                    end
                end
                default:
                begin
                    cls_keep = 1'b0;
                end
            endcase
        end
        if (cls.is_mem)
        begin
            cls.action = ACT_MEMORY;
        end
        ceil_sum = {1'b0, cls.bytes} + {18'd0, cfg.burst} - 34'd1;
        cls.da   = cls.addr;
        cls.db   = {14'd0, ceil_sum};
    end

    assign keep = cls_keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg  <= accept && cls_keep;
            mul_valid_reg <= chain_valid[DIV_STAGES];
            fin_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_item_reg <= cls;
    end

    assign chain_valid[0] = s0_valid_reg;
    assign chain_item[0]  = s0_item_reg;

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        mrc_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_item   (chain_item[g]),
            .burst     (cfg.burst),
            .chans     (cfg.chans),
            .out_valid (chain_valid[g+1]),
            .out_item  (chain_item[g+1])
        );
    end

    assign bursts = (chain_item[DIV_STAGES].qb == 34'd0) ? 34'd1 : chain_item[DIV_STAGES].qb;

    always_ff @(posedge clk)
    begin
        mul_item_reg <= chain_item[DIV_STAGES];
        prod_reg     <= bursts * cfg.cpb;
    end

    always_comb
    begin
        cyc      = {27'd0, cfg.base} + {1'b0, prod_reg};
        fin_next = '0;
        fin_next.action = mul_item_reg.action;
        fin_next.status = mul_item_reg.status;
        if (mul_item_reg.is_mem)
        begin
            fin_next.channel        = mul_item_reg.rc[7:0];
            fin_next.cycles         = (cyc > CYCLES_MAX) ? CYCLES_MAX[39:0] : cyc[39:0];
            fin_next.access_address = mul_item_reg.addr;
            fin_next.access_bytes   = mul_item_reg.bytes[32] ? 32'hFFFF_FFFF
                                                             : mul_item_reg.bytes[31:0];
            fin_next.needs_ready    = mul_item_reg.flags[3];
            fin_next.marks_valid    = mul_item_reg.flags[2];
            fin_next.then_compute   = mul_item_reg.flags[1];
            fin_next.then_fabric    = mul_item_reg.flags[0];
        end
        else
        begin
            fin_next.cycles = {24'd0, mul_item_reg.delay};
        end
    end

    always_ff @(posedge clk)
    begin
        fin_reg <= fin_next;
    end

    assign res_valid = fin_valid_reg;
    assign res       = fin_reg;

endmodule

// ===== rtl/mrc_queue.sv =====
// Result queue between the front pipeline and the output channel.
module mrc_queue import mrc_pkg::*; #(
    parameter int DEPTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  rsp_t push_data,
    input  logic pop,
    output logic head_valid,
    output rsp_t head_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rsp_t          mem [DEPTH];
    logic [PW-1:0] head_reg;
    logic [PW-1:0] head_next;
    logic [PW-1:0] tail_reg;
    logic [PW-1:0] tail_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    rsp_t          out_data_reg;
    logic          slot_free;
    logic          load_mem;
    logic          load_push;
    logic          write_mem;

    // The output register holds the head beat; the memory holds the beats behind it.
    always_comb
    begin
        slot_free  = !out_valid_reg || pop;
        load_mem   = slot_free && (count_reg != '0);
        load_push  = slot_free && (count_reg == '0) && push;
        write_mem  = push && !load_push;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (write_mem)
        begin
            tail_next = (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + PW'(1);
        end
        if (load_mem)
        begin
            head_next = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + PW'(1);
        end
        if (write_mem && !load_mem)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (load_mem && !write_mem)
        begin
            count_next = count_reg - CW'(1);
        end
        out_valid_next = slot_free ? (load_mem || load_push) : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_mem)
        begin
            mem[tail_reg] <= push_data;
        end
        if (load_mem)
        begin
            out_data_reg <= mem[head_reg];
        end
        else if (load_push)
        begin
            out_data_reg <= push_data;
        end
    end

    assign head_valid = out_valid_reg;
    assign head_data  = out_data_reg;

endmodule

// ===== rtl/memory_request_classifier_unit.sv =====
// Top level of the memory request classifier.
// Requests enter on req/req_valid/req_stall; one beat is taken at each rising edge
// with req_valid high and req_stall low. Each request gives at most one result
// beat on rsp/rsp_valid/rsp_stall; fabric requests with an undefined opcode give none.
// Results leave in request order. A request passes through the front
// pipeline: one classify stage, twelve divider stages of four quotient bits each
// that produce the channel and the burst count, one multiply stage and one
// result stage, then through the output register of the result queue.
// The block takes one request per cycle as long as the queue has room.
// req_stall rises only when results already in flight fill the QUEUE_DEPTH slots.
// While rsp_stall is high the head result holds and later results collect in
// the queue. Reset empties the pipeline and the queue and loads the register
// defaults. Registers are written through the APB port at byte address 8*i.
`include "memory_request_classifier_unit_defines.svh"
module memory_request_classifier_unit import mrc_pkg::*; #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_t        rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cfg_t          cfg;
    logic          accept;
    logic          keep;
    logic          res_valid;
    rsp_t          res;
    logic          pop;
    logic [CW-1:0] credit_reg;
    logic [CW-1:0] credit_next;

    mrc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign req_stall = (credit_reg == CW'(QUEUE_DEPTH));
    assign accept    = req_valid && !req_stall;
    assign pop       = rsp_valid && !rsp_stall;

    mrc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req       (req),
        .cfg       (cfg),
        .keep      (keep),
        .res_valid (res_valid),
        .res       (res)
    );

    mrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (res),
        .pop        (pop),
        .head_valid (rsp_valid),
        .head_data  (rsp)
    );

    always_comb
    begin
        credit_next = credit_reg;
        if ((accept && keep) && !pop)
        begin
            credit_next = credit_reg + CW'(1);
        end
        else if (pop && !(accept && keep))
        begin
            credit_next = credit_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
        end
    end

    `MRC_ASSERT_IMPL(a_credit_bound, 1'b1, credit_reg <= CW'(QUEUE_DEPTH), "credit overflow")
    `MRC_ASSERT_IMPL(a_rsp_has_credit, rsp_valid, credit_reg != '0, "result without credit")
    `MRC_ASSERT_IMPL(a_mem_status_ok, rsp_valid && rsp.action == ACT_MEMORY,
                     rsp.status == STATUS_OK && rsp.cycles != '0, "bad memory request")
    `MRC_ASSERT_NEXT(a_kept_counts, accept && keep && !pop, credit_reg != '0,
                     "kept request not counted")

endmodule

// ===== tb/memory_request_classifier_unit_test.sv =====
// Testbench for the memory request classifier: directed and random requests, predicted results, APB reconfiguration.
module memory_request_classifier_unit_test;
    import mrc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    memory_request_classifier_unit dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    cfg_t   cfg;
    req_t   pending_reqs[$];
    rsp_t   expected_rsps[$];
    int     mismatches;
    int     results_seen;
    int     memory_results;
    int     invalid_results;
    longint cycle_count;
    int     req_gap;
    int     rsp_gap;
    bit     hold_rsp;
    int     hold_cycles;
    bit     hold_request;
    bit     hold_done;
    bit     draining;
    bit     in_flight;
    int     sent;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [63:0] one_if_zero(input logic [63:0] v);
        return (v == 0) ? 64'd1 : v;
    endfunction

    function automatic logic in_range(input logic [47:0] a, input logic [63:0] n);
        if (a > cfg.capacity)
            return 1'b0;
        return n <= ({16'd0, cfg.capacity} - {16'd0, a});
    endfunction

    function automatic rsp_t dispatch_rsp(input logic [1:0] act, input logic st,
                                          input logic [15:0] dly);
        rsp_t r;
        r = '0;
        r.action = act;
        r.status = st;
        r.cycles = (dly == 0) ? 40'd1 : {24'd0, dly};
        return r;
    endfunction

    function automatic rsp_t memory_rsp(input logic [47:0] a, input logic [63:0] n,
                                        input logic [3:0] fl);
        rsp_t       r;
        logic [63:0] gran;
        logic [63:0] chans;
        logic [63:0] nb;
        logic [63:0] cyc;
        gran = one_if_zero({48'd0, cfg.burst});
        chans = one_if_zero({55'd0, cfg.chans});
        if (chans > 256)
            chans = 256;
        nb = (n + gran - 1) / gran;
        if (nb == 0)
            nb = 1;
        cyc = one_if_zero({48'd0, cfg.base}) + nb * one_if_zero({56'd0, cfg.cpb});
        if (cyc > 64'hFF_FFFF_FFFF)
            cyc = 64'hFF_FFFF_FFFF;
        r = '0;
        r.action = ACT_MEMORY;
        r.status = STATUS_OK;
        r.channel = 8'(({16'd0, a} / gran) % chans);
        r.cycles = cyc[39:0];
        r.access_address = a;
        r.access_bytes = (n > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : n[31:0];
        {r.needs_ready, r.marks_valid, r.then_compute, r.then_fabric} = fl;
        return r;
    endfunction

    function automatic bit classify_request(input req_t q, output rsp_t r);
        logic [63:0] n;
        logic [63:0] deg;
        logic [63:0] tb;
        n = (q.byte_count != 0) ? {32'd0, q.byte_count}
                                : one_if_zero({39'd0, q.elem_count}) * 4;
        if (q.mode == MODE_COMPUTE)
        begin
            if (q.opcode != OP_STORE)
                r = dispatch_rsp(ACT_COMPLETE, STATUS_OK, cfg.ret_delay);
            else if (!in_range(q.mem_address, n))
                r = dispatch_rsp(ACT_COMPLETE, STATUS_INVALID, cfg.ret_delay);
            else
                r = memory_rsp(q.mem_address, n, 4'b0101);
            return 1'b1;
        end
        if (q.opcode <= OP_LOAD)
        begin
            if (!in_range(q.mem_address, n))
                r = dispatch_rsp(ACT_COMPLETE, STATUS_INVALID, cfg.ret_delay);
            else if (q.opcode == OP_H2D)
                r = memory_rsp(q.mem_address, n, 4'b0101);
            else if (q.opcode == OP_D2H)
                r = memory_rsp(q.mem_address, n, 4'b1001);
            else
                r = memory_rsp(q.mem_address, n, 4'b1010);
            return 1'b1;
        end
        if (q.opcode <= OP_BARRIER)
        begin
            r = dispatch_rsp(ACT_COMPUTE, STATUS_OK, cfg.cmp_delay);
            return 1'b1;
        end
        if (q.opcode <= OP_INTT)
        begin
            if (cfg.twiddle_en)
            begin
                deg = (q.poly_deg != 0) ? {39'd0, q.poly_deg}
                    : (q.elem_count != 0) ? {39'd0, q.elem_count}
                    : {39'd0, DEFAULT_POLY_DEGREE};
                if (deg < 2)
                    deg = 2;
                tb = (deg / 2) * 4;
                if (!in_range(q.twiddle_addr, tb))
                    r = dispatch_rsp(ACT_COMPLETE, STATUS_INVALID, cfg.ret_delay);
                else
                    r = memory_rsp(q.twiddle_addr, tb, 4'b1010);
            end
            else
                r = dispatch_rsp(ACT_COMPUTE, STATUS_OK, cfg.cmp_delay);
            return 1'b1;
        end
        r = '0;
        return 1'b0;
    endfunction

    function automatic logic [47:0] pick_addr();
        case ($urandom_range(0, 5))
            0: return 48'd0;
            1: return 48'hFFFF_FFFF_FFFF;
            2: return cfg.capacity - 48'($urandom_range(0, 300));
            3: return cfg.capacity + 48'($urandom_range(0, 3));
            4: return 48'({$urandom, $urandom});
            default: return 48'($urandom_range(0, 1 << 20));
        endcase
    endfunction

    function automatic req_t random_request();
        req_t q;
        q.mode = $urandom_range(0, 3) == 0 ? MODE_COMPUTE : MODE_FABRIC;
        q.opcode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                                 : 4'($urandom_range(0, 11));
        q.mem_address = pick_addr();
        q.twiddle_addr = pick_addr();
        case ($urandom_range(0, 3))
            0: q.byte_count = 32'd0;
            1: q.byte_count = $urandom;
            2: q.byte_count = 32'hFFFF_FFFF;
            default: q.byte_count = 32'($urandom_range(1, 4096));
        endcase
        q.elem_count = ($urandom_range(0, 3) == 0) ? 25'd0
                     : ($urandom_range(0, 1) ? 25'($urandom) : 25'($urandom_range(1, 5000)));
        q.poly_deg = ($urandom_range(0, 2) == 0) ? 25'd0
                   : ($urandom_range(0, 1) ? 25'($urandom) : 25'($urandom_range(1, 3)));
        return q;
    endfunction

    task automatic apb_write(input logic [2:0] idx, input logic [63:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_CAPACITY:   cfg.capacity = val[47:0];
            REG_BURST:      cfg.burst = val[15:0];
            REG_BASE:       cfg.base = val[15:0];
            REG_CPB:        cfg.cpb = val[7:0];
            REG_CMP_DELAY:  cfg.cmp_delay = val[15:0];
            REG_RET_DELAY:  cfg.ret_delay = val[15:0];
            REG_TWIDDLE_EN: cfg.twiddle_en = val[0];
            REG_CHANNELS:   cfg.chans = val[8:0];
            default:        ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || in_flight)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic queue_request(input req_t q);
        pending_reqs = {pending_reqs, q};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            req_gap <= 0;
            in_flight <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                rsp_t r;
                if (classify_request(req, r))
                    expected_rsps = {expected_rsps, r};
                sent++;
            end
            if (!req_valid || !req_stall)
            begin
                if (req_gap > 0 || pending_reqs.size() == 0)
                begin
                    req_valid <= 1'b0;
                    if (req_gap > 0)
                        req_gap <= req_gap - 1;
                    in_flight <= pending_reqs.size() != 0;
                end
                else
                begin
                    req <= pending_reqs[0];
                    pending_reqs.delete(0);
                    req_valid <= 1'b1;
                    in_flight <= 1'b1;
                    req_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rsp_gap <= 0;
            hold_cycles <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                rsp_t e;
                results_seen++;
                if (expected_rsps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %p", rsp);
                end
                else
                begin
                    e = expected_rsps[0];
                    expected_rsps.delete(0);
                    if (rsp.action == ACT_MEMORY)
                        memory_results++;
                    if (rsp.status == STATUS_INVALID)
                        invalid_results++;
                    if (rsp.action != e.action || rsp.status != e.status
                        || rsp.channel != e.channel || rsp.cycles != e.cycles
                        || rsp.access_address != e.access_address
                        || rsp.access_bytes != e.access_bytes
                        || rsp.needs_ready != e.needs_ready
                        || rsp.marks_valid != e.marks_valid
                        || rsp.then_compute != e.then_compute
                        || rsp.then_fabric != e.then_fabric)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %p, got %p", e, rsp);
                    end
                end
            end
            if (hold_request && !hold_done)
            begin
                rsp_stall <= 1'b1;
                if (hold_cycles == 400)
                    hold_done <= 1'b1;
                hold_cycles <= hold_cycles + 1;
            end
            else if (rsp_gap > 0)
            begin
                rsp_stall <= 1'b1;
                rsp_gap <= rsp_gap - 1;
            end
            else if (draining || $urandom_range(0, 3) != 0)
            begin
                rsp_stall <= 1'b0;
                if (rsp_valid && !rsp_stall && !draining)
                    rsp_gap <= $urandom_range(0, 16);
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** memory_request_classifier_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        req_t q;
        logic [15:0] b16;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        results_seen = 0;
        memory_results = 0;
        invalid_results = 0;
        cycle_count = 0;
        hold_request = 1'b0;
        draining = 1'b0;
        sent = 0;
        cfg.capacity = 48'd17179869184;
        cfg.burst = 16'd64;
        cfg.base = 16'd24;
        cfg.cpb = 8'd2;
        cfg.cmp_delay = 16'd2;
        cfg.ret_delay = 16'd4;
        cfg.twiddle_en = 1'b0;
        cfg.chans = 9'd16;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 2; ph++)
        begin
            for (int op = 0; op < 16; op++)
            begin
                q = '0;
                q.mode = (op == 3) ? MODE_COMPUTE : MODE_FABRIC;
                q.opcode = 4'(op);
                q.mem_address = (op == 2) ? 48'hFFFF_FFFF_FFFF : 48'(op * 64);
                q.byte_count = (op == 0) ? 32'hFFFF_FFFF : 32'd0;
                q.elem_count = (op == 1) ? 25'd16777216 : 25'd0;
                q.poly_deg = (op == 10) ? 25'd1 : ((op == 11) ? 25'd16777216 : 25'd0);
                q.twiddle_addr = (op == 11) ? cfg.capacity : 48'd0;
                queue_request(q);
            end
            q.mode = MODE_COMPUTE;
            q.opcode = OP_ADD;
            queue_request(q);
            wait_idle();
            apb_write(REG_TWIDDLE_EN, 64'd1);
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    apb_write(REG_CAPACITY, 64'hFFFF_FFFF_FFFF);
                    apb_write(REG_BURST, 64'd0);
                    apb_write(REG_BASE, 64'd0);
                    apb_write(REG_CPB, 64'd0);
                    apb_write(REG_CMP_DELAY, 64'd0);
                    apb_write(REG_RET_DELAY, 64'd0);
                    apb_write(REG_CHANNELS, 64'd0);
                end
                1:
                begin
                    apb_write(REG_CAPACITY, 64'd0);
                    apb_write(REG_BURST, 64'hFFFF);
                    apb_write(REG_BASE, 64'hFFFF);
                    apb_write(REG_CPB, 64'hFF);
                    apb_write(REG_CMP_DELAY, 64'hFFFF);
                    apb_write(REG_RET_DELAY, 64'hFFFF);
                    apb_write(REG_CHANNELS, 64'd511);
                    apb_write(REG_TWIDDLE_EN, 64'd0);
                end
                default:
                begin
                    b16 = 16'($urandom_range(1, 4096));
                    apb_write(REG_CAPACITY, {16'd0, $urandom_range(0, 1) ? 48'd17179869184
                                                  : 48'($urandom) << 8});
                    apb_write(REG_BURST, {48'd0, b16});
                    apb_write(REG_BASE, 64'($urandom_range(0, 65535)));
                    apb_write(REG_CPB, 64'($urandom_range(0, 255)));
                    apb_write(REG_CMP_DELAY, 64'($urandom_range(0, 65535)));
                    apb_write(REG_RET_DELAY, 64'($urandom_range(0, 65535)));
                    apb_write(REG_TWIDDLE_EN, 64'($urandom_range(0, 1)));
                    apb_write(REG_CHANNELS, 64'($urandom_range(0, 300)));
                end
            endcase
            if (ph == 3)
                hold_request = 1'b1;
            for (int i = 0; i < 240; i++)
                queue_request(random_request());
            wait_idle();
        end

        draining = 1'b1;
        wait_idle();
        $display("%0d requests sent, %0d results checked (%0d memory, %0d invalid address)",
                 sent, results_seen, memory_results, invalid_results);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("** memory_request_classifier_unit: PASSED **");
        else
            $display("** memory_request_classifier_unit: FAILED **");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/mrc_pkg.sv
rtl/mrc_cfg.sv
rtl/mrc_div_stage.sv
rtl/mrc_front.sv
rtl/mrc_queue.sv
rtl/memory_request_classifier_unit.sv
tb/memory_request_classifier_unit_test.sv
